/* sv/hierarchical_timer_wheel_defines.svh */
// assertion macros for the timer wheel port checker
`ifndef HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH
`define HIERARCHICAL_TIMER_WHEEL_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define HTW_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("timer wheel check failed");

// next-cycle implication, sampled on clock, off during reset
`define HTW_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("timer wheel check failed");

`endif

/* sv/htw_pkg.sv */
// shared constants, codes and bucket helpers for the timer wheel
`timescale 1ns / 1ps

package htw_pkg;

   localparam int LEVEL_BITS = 6;
   localparam int LEVELS     = 4;
   localparam int MAX_TIMERS = 64;

   localparam int SLOTS     = 1 << LEVEL_BITS;
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int BKT_W     = LVL_W + LEVEL_BITS;
   localparam int BUCKETS   = LEVELS * SLOTS;
   localparam int ID_W      = $clog2(MAX_TIMERS);
   localparam int LINK_W    = ID_W + 1;
   localparam int CNT_W     = $clog2(MAX_TIMERS + 1);
   localparam int SPAN_BITS = LEVELS * LEVEL_BITS;
   localparam int NOW_W     = 32;
   localparam int TMO_W     = 24;
   localparam int KIND_W    = 3;

   localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_TIMERS);

   typedef enum logic [1:0] {
      REQ_TICK     = 2'd0,
      REQ_REGISTER = 2'd1,
      REQ_CANCEL   = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_FIRED    = 3'd0,
      KIND_ACCEPTED = 3'd1,
      KIND_BUSY     = 3'd2,
      KIND_RANGE    = 3'd3,
      KIND_UNKNOWN  = 3'd4
   } kind_type;

   // lowest level whose span covers expiry - now, and the expiry slice there
   function automatic logic [BKT_W-1:0] place_bucket(input logic [NOW_W-1:0] expiry,
                                                     input logic [NOW_W-1:0] now);
      logic [NOW_W-1:0]      delta;
      logic [LVL_W-1:0]      lvl;
      logic [LEVEL_BITS-1:0] slot;
      logic                  found;
      delta = expiry - now;
      lvl   = LVL_W'(LEVELS - 1);
      slot  = LEVEL_BITS'(64'(expiry) >> (LEVEL_BITS * (LEVELS - 1)));
      found = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (!found && ((64'(delta) >> (LEVEL_BITS * (l + 1))) == 64'd0)) begin
            found = 1'b1;
            lvl   = LVL_W'(l);
            slot  = LEVEL_BITS'(64'(expiry) >> (LEVEL_BITS * l));
         end
      end
      return {lvl, slot};
   endfunction

   // slice of the jiffy counter that indexes a given level
   function automatic logic [LEVEL_BITS-1:0] now_slot(input logic [NOW_W-1:0] now,
                                                      input logic [LVL_W-1:0] lvl);
      logic [LEVEL_BITS-1:0] slot;
      slot = '0;
      for (int l = 0; l < LEVELS; l++) begin
         if (lvl == LVL_W'(l)) begin
            slot = LEVEL_BITS'(64'(now) >> (LEVEL_BITS * l));
         end
      end
      return slot;
   endfunction

endpackage

/* sv/hierarchical_timer_wheel.sv */
// hierarchical timing wheel with cascading, one sequencer over shared bucket memories
//
//   channel | direction | payload                                          | flow
//   req_    | in        | req_type, timer_id, timeout, periodic            | valid / stall
//   rsp_    | out       | result_kind, fired_id, tick_count, last          | valid / stall
//
// work per item, ending in its response transfers: cancel, busy and range answer directly;
//   register places the timer first. tick: each cascaded level first re-places its entries
//   one by one, then the level-0 bucket is walked entry by entry; each fired timer is then
//   emitted, and re-placed when it re-arms. the single-ported bucket lists set this order.
// reset: synchronous; jiffy counter to one, all buckets empty through per-bucket valid bits.
// a stalled response holds the block; no request is taken until the item is finished.
`timescale 1ns / 1ps

module hierarchical_timer_wheel (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_type,
   input  logic [htw_pkg::ID_W-1:0]             req_timer_id,
   input  logic [htw_pkg::TMO_W-1:0]            req_timeout,
   input  logic                                 req_periodic,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [htw_pkg::KIND_W-1:0]           rsp_result_kind,
   output logic [htw_pkg::ID_W-1:0]             rsp_fired_id,
   output logic [htw_pkg::NOW_W-1:0]            rsp_tick_count,
   output logic                                 rsp_last
);

   localparam int ID_W   = htw_pkg::ID_W;
   localparam int LINK_W = htw_pkg::LINK_W;
   localparam int CNT_W  = htw_pkg::CNT_W;
   localparam int BKT_W  = htw_pkg::BKT_W;
   localparam int LVL_W  = htw_pkg::LVL_W;
   localparam int LB     = htw_pkg::LEVEL_BITS;
   localparam int NOW_W  = htw_pkg::NOW_W;
   localparam int TMO_W  = htw_pkg::TMO_W;
   localparam int KIND_W = htw_pkg::KIND_W;
   localparam int NT     = htw_pkg::MAX_TIMERS;
   localparam int NB     = htw_pkg::BUCKETS;

   // sequencer states, one-hot
   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_OUT      = 20'h00002,
      ST_REG_RSP  = 20'h00004,
      ST_CS_HEAD  = 20'h00008,
      ST_CS_HWAIT = 20'h00010,
      ST_CS_NODE  = 20'h00020,
      ST_CS_NWAIT = 20'h00040,
      ST_CS_NEXT  = 20'h00080,
      ST_FH       = 20'h00100,
      ST_FHW      = 20'h00200,
      ST_FN       = 20'h00400,
      ST_FNW      = 20'h00800,
      ST_EM_RD    = 20'h01000,
      ST_EM_ID    = 20'h02000,
      ST_EM_ARM   = 20'h04000,
      ST_EM_ARMW  = 20'h08000,
      ST_EM_NEXT  = 20'h10000,
      ST_PL_RD    = 20'h20000,
      ST_PL_WAIT  = 20'h40000,
      ST_PL_LINK  = 20'h80000
   } state_type;

   // control state
   state_type               state_ff, state_in;
   state_type               out_ret_ff, out_ret_in;   // where to go after a response transfer
   state_type               pl_ret_ff, pl_ret_in;     // where to go after a placement
   logic [NOW_W-1:0]        now_ff, now_in;
   logic [NT-1:0]           in_use_ff, in_use_in;
   logic [NT-1:0]           canc_ff, canc_in;
   logic [NB-1:0]           hv_ff, hv_in;             // bucket head valid, else empty
   logic                    rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [NOW_W-1:0]        old_now_ff, old_now_in;
   logic [LVL_W-1:0]        lvl_ff, lvl_in;
   logic [LINK_W-1:0]       cur_ff, cur_in;
   logic [LINK_W-1:0]       nxt_ff, nxt_in;
   logic [CNT_W-1:0]        guard_ff, guard_in;
   logic [CNT_W-1:0]        nf_ff, nf_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [ID_W-1:0]         t_ff, t_in;
   logic [ID_W-1:0]         pl_id_ff, pl_id_in;
   logic [NOW_W-1:0]        pl_exp_ff, pl_exp_in;
   logic [BKT_W-1:0]        pl_b_ff, pl_b_in;

   // response register
   logic [KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic [NOW_W-1:0]        rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_last_ff, rsp_last_in;

   // memories
   logic [NOW_W-1:0]        exp_mem [NT];
   logic [TMO_W:0]          ivl_mem [NT];             // {repeat, interval}
   logic [LINK_W-1:0]       link_mem [NT];
   logic [LINK_W-1:0]       head_mem [NB];
   logic [ID_W-1:0]         tail_mem [NB];
   logic [ID_W-1:0]         fired_mem [NT];

   logic [NOW_W-1:0]        exp_rd_ff;
   logic [TMO_W:0]          ivl_rd_ff;
   logic [LINK_W-1:0]       link_rd_ff;
   logic [LINK_W-1:0]       head_rd_ff;
   logic [ID_W-1:0]         tail_rd_ff;
   logic                    hv_rd_ff;
   logic [ID_W-1:0]         fired_rd_ff;

   // memory write controls
   logic                    exp_we;
   logic [ID_W-1:0]         exp_wa;
   logic [NOW_W-1:0]        exp_wd;
   logic                    ivl_we;
   logic                    link_we;
   logic [ID_W-1:0]         link_wa;
   logic [LINK_W-1:0]       link_wd;
   logic                    head_we;
   logic                    tail_we;
   logic                    fired_we;
   logic [BKT_W-1:0]        head_ra;

   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    id_bad;
   logic                    tmo_bad;
   logic [BKT_W-1:0]        cs_bkt;
   logic [BKT_W-1:0]        fire_bkt;
   logic                    list_done;
   logic [ID_W-1:0]         cur_id;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_fired_id    = rsp_id_ff;
   assign rsp_tick_count  = rsp_cnt_ff;
   assign rsp_last        = rsp_last_ff;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   // request checks: id beyond the timer table, timeout zero or beyond the top level span
   assign id_bad  = (32'(req_timer_id) >= NT);
   assign tmo_bad = (req_timeout == '0) ||
                    ((64'(req_timeout) >> htw_pkg::SPAN_BITS) != 64'd0);

   assign cs_bkt    = {lvl_ff, htw_pkg::now_slot(now_ff, lvl_ff)};
   assign fire_bkt  = {LVL_W'(0), old_now_ff[LB-1:0]};
   assign list_done = (cur_ff >= htw_pkg::LIST_END) || (guard_ff == CNT_W'(NT));
   assign cur_id    = cur_ff[ID_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      out_ret_in   = out_ret_ff;
      pl_ret_in    = pl_ret_ff;
      now_in       = now_ff;
      in_use_in    = in_use_ff;
      canc_in      = canc_ff;
      hv_in        = hv_ff;
      rsp_valid_in = rsp_valid_ff;
      old_now_in   = old_now_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      guard_in     = guard_ff;
      nf_in        = nf_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      pl_id_in     = pl_id_ff;
      pl_exp_in    = pl_exp_ff;
      pl_b_in      = pl_b_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      exp_we       = 1'b0;
      exp_wa       = pl_id_ff;
      exp_wd       = pl_exp_ff;
      ivl_we       = 1'b0;
      link_we      = 1'b0;
      link_wa      = pl_id_ff;
      link_wd      = htw_pkg::LIST_END;
      head_we      = 1'b0;
      tail_we      = 1'b0;
      fired_we     = 1'b0;
      head_ra      = pl_b_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               rsp_id_in   = req_timer_id;
               rsp_cnt_in  = now_ff;
               rsp_last_in = 1'b1;
               out_ret_in  = ST_IDLE;
               case (req_type)
                  htw_pkg::REQ_TICK: begin
                     old_now_in = now_ff;
                     if (now_ff[LB-1:0] == '0) begin
                        lvl_in   = LVL_W'(1);
                        state_in = ST_CS_HEAD;
                     end else begin
                        state_in = ST_FH;
                     end
                  end
                  htw_pkg::REQ_REGISTER: begin
                     if (id_bad) begin
                        rsp_kind_in  = htw_pkg::KIND_UNKNOWN;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_OUT;
                     end else if (tmo_bad) begin
                        rsp_kind_in  = htw_pkg::KIND_RANGE;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_OUT;
                     end else if (in_use_ff[req_timer_id]) begin
                        rsp_kind_in  = htw_pkg::KIND_BUSY;
                        rsp_valid_in = 1'b1;
                        state_in     = ST_OUT;
                     end else begin
                        // arm and place, respond once the bucket list is linked
                        in_use_in[req_timer_id] = 1'b1;
                        canc_in[req_timer_id]   = 1'b0;
                        ivl_we    = 1'b1;
                        exp_we    = 1'b1;
                        exp_wa    = req_timer_id;
                        exp_wd    = now_ff + NOW_W'(req_timeout);
                        pl_id_in  = req_timer_id;
                        pl_exp_in = now_ff + NOW_W'(req_timeout);
                        pl_ret_in = ST_REG_RSP;
                        state_in  = ST_PL_RD;
                     end
                  end
                  htw_pkg::REQ_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_OUT;
                     if (id_bad || !in_use_ff[req_timer_id] || canc_ff[req_timer_id]) begin
                        rsp_kind_in = htw_pkg::KIND_UNKNOWN;
                     end else begin
                        // the mark drops the entry when its level-0 bucket is served
                        canc_in[req_timer_id] = 1'b1;
                        rsp_kind_in           = htw_pkg::KIND_ACCEPTED;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_OUT: begin
            if (rsp_xfer) begin
               rsp_valid_in = 1'b0;
               state_in     = out_ret_ff;
            end
         end

         ST_REG_RSP: begin
            rsp_kind_in  = htw_pkg::KIND_ACCEPTED;
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT;
         end

         // placement: read head and tail of the target bucket, then append
         ST_PL_RD: begin
            head_ra  = htw_pkg::place_bucket(pl_exp_ff, now_ff);
            pl_b_in  = htw_pkg::place_bucket(pl_exp_ff, now_ff);
            state_in = ST_PL_WAIT;
         end
         ST_PL_WAIT: begin
            if (!hv_rd_ff) begin
               head_we        = 1'b1;
               hv_in[pl_b_ff] = 1'b1;
            end else begin
               link_we = 1'b1;
               link_wa = tail_rd_ff;
               link_wd = {1'b0, pl_id_ff};
            end
            tail_we  = 1'b1;
            state_in = ST_PL_LINK;
         end
         ST_PL_LINK: begin
            link_we  = 1'b1;
            link_wa  = pl_id_ff;
            link_wd  = htw_pkg::LIST_END;
            state_in = pl_ret_ff;
         end

         // cascade: detach a higher-level bucket and re-place each entry
         ST_CS_HEAD: begin
            head_ra  = cs_bkt;
            state_in = ST_CS_HWAIT;
         end
         ST_CS_HWAIT: begin
            cur_in        = hv_rd_ff ? head_rd_ff : htw_pkg::LIST_END;
            hv_in[cs_bkt] = 1'b0;
            guard_in      = '0;
            state_in      = ST_CS_NODE;
         end
         ST_CS_NODE: begin
            if (list_done) begin
               // climb only while the slot taken at this level is zero
               if ((cs_bkt[LB-1:0] != '0) || (lvl_ff == LVL_W'(htw_pkg::LEVELS - 1))) begin
                  state_in = ST_FH;
               end else begin
                  lvl_in   = lvl_ff + LVL_W'(1);
                  state_in = ST_CS_HEAD;
               end
            end else begin
               state_in = ST_CS_NWAIT;
            end
         end
         ST_CS_NWAIT: begin
            nxt_in    = link_rd_ff;
            pl_id_in  = cur_id;
            pl_exp_in = exp_rd_ff;
            pl_ret_in = ST_CS_NEXT;
            state_in  = ST_PL_RD;
         end
         ST_CS_NEXT: begin
            cur_in   = nxt_ff;
            guard_in = guard_ff + CNT_W'(1);
            state_in = ST_CS_NODE;
         end

         // fire: detach the level-0 bucket, free cancelled entries, list the rest
         ST_FH: begin
            head_ra  = fire_bkt;
            state_in = ST_FHW;
         end
         ST_FHW: begin
            cur_in          = hv_rd_ff ? head_rd_ff : htw_pkg::LIST_END;
            hv_in[fire_bkt] = 1'b0;
            guard_in        = '0;
            nf_in           = '0;
            state_in        = ST_FN;
         end
         ST_FN: begin
            if (list_done) begin
               now_in   = now_ff + NOW_W'(1);
               k_in     = '0;
               state_in = (nf_ff == '0) ? ST_IDLE : ST_EM_RD;
            end else begin
               state_in = ST_FNW;
            end
         end
         ST_FNW: begin
            if (canc_ff[cur_id]) begin
               canc_in[cur_id]   = 1'b0;
               in_use_in[cur_id] = 1'b0;
            end else if (nf_ff < CNT_W'(NT)) begin
               fired_we = 1'b1;
               nf_in    = nf_ff + CNT_W'(1);
            end
            cur_in   = link_rd_ff;
            guard_in = guard_ff + CNT_W'(1);
            state_in = ST_FN;
         end

         // emit fired timers in list order, then re-arm or free each
         ST_EM_RD: begin
            state_in = ST_EM_ID;
         end
         ST_EM_ID: begin
            t_in         = fired_rd_ff;
            rsp_kind_in  = htw_pkg::KIND_FIRED;
            rsp_id_in    = fired_rd_ff;
            rsp_cnt_in   = now_ff;
            rsp_last_in  = ((k_ff + CNT_W'(1)) == nf_ff);
            rsp_valid_in = 1'b1;
            out_ret_in   = ST_EM_ARM;
            state_in     = ST_OUT;
         end
         ST_EM_ARM: begin
            state_in = ST_EM_ARMW;
         end
         ST_EM_ARMW: begin
            if (ivl_rd_ff[TMO_W]) begin
               // periodic: next expiry counts from the jiffy the tick started at
               exp_we    = 1'b1;
               exp_wa    = t_ff;
               exp_wd    = old_now_ff + NOW_W'(ivl_rd_ff[TMO_W-1:0]);
               pl_id_in  = t_ff;
               pl_exp_in = old_now_ff + NOW_W'(ivl_rd_ff[TMO_W-1:0]);
               pl_ret_in = ST_EM_NEXT;
               state_in  = ST_PL_RD;
            end else begin
               in_use_in[t_ff] = 1'b0;
               state_in        = ST_EM_NEXT;
            end
         end
         ST_EM_NEXT: begin
            k_in     = k_ff + CNT_W'(1);
            state_in = ((k_ff + CNT_W'(1)) == nf_ff) ? ST_IDLE : ST_EM_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_ret_ff   <= ST_IDLE;
         pl_ret_ff    <= ST_IDLE;
         now_ff       <= NOW_W'(1);
         in_use_ff    <= '0;
         canc_ff      <= '0;
         hv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_ret_ff   <= out_ret_in;
         pl_ret_ff    <= pl_ret_in;
         now_ff       <= now_in;
         in_use_ff    <= in_use_in;
         canc_ff      <= canc_in;
         hv_ff        <= hv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and response registers
   always_ff @(posedge clock) begin
      old_now_ff  <= old_now_in;
      lvl_ff      <= lvl_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      guard_ff    <= guard_in;
      nf_ff       <= nf_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      pl_id_ff    <= pl_id_in;
      pl_exp_ff   <= pl_exp_in;
      pl_b_ff     <= pl_b_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_last_ff <= rsp_last_in;
   end

   // per-timer memories
   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[exp_wa] <= exp_wd;
      end
      if (ivl_we) begin
         ivl_mem[req_timer_id] <= {req_periodic, req_timeout};
      end
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (fired_we) begin
         fired_mem[nf_ff[ID_W-1:0]] <= cur_id;
      end
      exp_rd_ff   <= exp_mem[cur_id];
      link_rd_ff  <= link_mem[cur_id];
      ivl_rd_ff   <= ivl_mem[t_ff];
      fired_rd_ff <= fired_mem[k_ff[ID_W-1:0]];
   end

   // bucket list memories
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[pl_b_ff] <= {1'b0, pl_id_ff};
      end
      if (tail_we) begin
         tail_mem[pl_b_ff] <= pl_id_ff;
      end
      head_rd_ff <= head_mem[head_ra];
      tail_rd_ff <= tail_mem[head_ra];
      hv_rd_ff   <= hv_ff[head_ra];
   end

endmodule

/* sv/htw_checker.sv */
// port-level checker for the timer wheel and its bind
`timescale 1ns / 1ps
`include "hierarchical_timer_wheel_defines.svh"

module htw_port_checks (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_type,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [htw_pkg::KIND_W-1:0]           rsp_result_kind,
   input logic [htw_pkg::ID_W-1:0]             rsp_fired_id,
   input logic [htw_pkg::NOW_W-1:0]            rsp_tick_count,
   input logic                                 rsp_last
);

   // a stalled response keeps its payload
   `HTW_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_result_kind) && $stable(rsp_fired_id) && $stable(rsp_tick_count) && $stable(rsp_last))

   // no new request is taken while a response waits
   `HTW_ASSERT_SAME(a_busy_with_rsp, rsp_valid, req_stall)

   // a real request keeps the block busy in the following cycle
   `HTW_ASSERT_NEXT(a_req_busy, req_valid && !req_stall && req_type != htw_pkg::REQ_UNUSED, req_stall)

   // only fired results come in groups; every other kind is the sole transfer of its item
   `HTW_ASSERT_SAME(a_single_rsp_last, rsp_valid && rsp_result_kind != htw_pkg::KIND_FIRED, rsp_last)

endmodule

bind hierarchical_timer_wheel htw_port_checks u_htw_port_checks (.*);

/* verif/htw_checker.sv */
// checker for the timer wheel: tracks accepted requests, predicts responses, compares them
`timescale 1ns / 1ps

module htw_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [htw_pkg::ID_W-1:0]     req_timer_id,
   input  logic [htw_pkg::TMO_W-1:0]    req_timeout,
   input  logic                         req_periodic,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [htw_pkg::KIND_W-1:0]   rsp_result_kind,
   input  logic [htw_pkg::ID_W-1:0]     rsp_fired_id,
   input  logic [htw_pkg::NOW_W-1:0]    rsp_tick_count,
   input  logic                         rsp_last,
   output int                           fail_count,
   output int                           pending_count,
   output int                           fired_count
);

   typedef struct packed {
      logic [htw_pkg::KIND_W-1:0] kind;
      logic [htw_pkg::ID_W-1:0]   id;
      logic [htw_pkg::NOW_W-1:0]  count;
      logic                       last;
   } outcome_type;

   outcome_type outcome_q[$];

   logic [htw_pkg::NOW_W-1:0]  jiffies;
   logic [htw_pkg::NOW_W-1:0]  due_at[htw_pkg::MAX_TIMERS];
   logic [htw_pkg::TMO_W-1:0]  rearm_gap[htw_pkg::MAX_TIMERS];
   logic                       rearm[htw_pkg::MAX_TIMERS];
   logic                       armed[htw_pkg::MAX_TIMERS];
   logic                       killed[htw_pkg::MAX_TIMERS];
   int                         chain_next[htw_pkg::MAX_TIMERS];
   int                         slot_first[htw_pkg::BUCKETS];
   int                         slot_last[htw_pkg::BUCKETS];

   function automatic void link_in(int b, int id);
      chain_next[id] = htw_pkg::MAX_TIMERS;
      if (slot_first[b] == htw_pkg::MAX_TIMERS) slot_first[b] = id;
      else chain_next[slot_last[b]] = id;
      slot_last[b] = id;
   endfunction

   function automatic void file_timer(int id);
      logic [htw_pkg::NOW_W-1:0] delta;
      int lvl;
      int slot;
      delta = due_at[id] - jiffies;
      lvl = htw_pkg::LEVELS - 1;
      for (int l = htw_pkg::LEVELS - 1; l >= 0; l--)
         if ((64'(delta) >> (htw_pkg::LEVEL_BITS * (l + 1))) == 0) lvl = l;
      slot = int'((64'(due_at[id]) >> (htw_pkg::LEVEL_BITS * lvl)) & (htw_pkg::SLOTS - 1));
      link_in(lvl * htw_pkg::SLOTS + slot, id);
   endfunction

   function automatic int jiffy_slot(int lvl);
      return int'((64'(jiffies) >> (htw_pkg::LEVEL_BITS * lvl)) & (htw_pkg::SLOTS - 1));
   endfunction

   // append one expected transfer at the current jiffy count
   function automatic void enqueue(logic [htw_pkg::KIND_W-1:0] k, int id, logic lst);
      outcome_type o;
      o.kind = k;
      o.id = htw_pkg::ID_W'(id);
      o.count = jiffies;
      o.last = lst;
      outcome_q = {outcome_q, o};
   endfunction

   function automatic void push_one(logic [htw_pkg::KIND_W-1:0] k, int id);
      enqueue(k, id, 1'b1);
   endfunction

   // advance the wheel model by one request and queue what it produces
   function automatic void wheel_step(logic [1:0] rt, int id, logic [htw_pkg::TMO_W-1:0] tmo,
                                      logic per);
      int fired[$];
      int idx;
      int cur;
      int nxt;
      int s;
      int b;
      logic [htw_pkg::NOW_W-1:0] prev;
      if (rt == htw_pkg::REQ_TICK) begin
         idx = jiffy_slot(0);
         prev = jiffies;
         if (idx == 0) begin
            for (int l = 1; l < htw_pkg::LEVELS; l++) begin
               s = jiffy_slot(l);
               b = l * htw_pkg::SLOTS + s;
               cur = slot_first[b];
               slot_first[b] = htw_pkg::MAX_TIMERS;
               while (cur < htw_pkg::MAX_TIMERS) begin
                  nxt = chain_next[cur];
                  file_timer(cur);
                  cur = nxt;
               end
               if (s != 0) break;
            end
         end
         cur = slot_first[idx];
         slot_first[idx] = htw_pkg::MAX_TIMERS;
         while (cur < htw_pkg::MAX_TIMERS) begin
            nxt = chain_next[cur];
            if (killed[cur]) begin
               killed[cur] = 1'b0;
               armed[cur] = 1'b0;
            end else fired = {fired, cur};
            cur = nxt;
         end
         jiffies = prev + 1;
         foreach (fired[k])
            enqueue(htw_pkg::KIND_FIRED, fired[k], k == fired.size() - 1);
         foreach (fired[k]) begin
            if (rearm[fired[k]]) begin
               due_at[fired[k]] = prev + htw_pkg::NOW_W'(rearm_gap[fired[k]]);
               file_timer(fired[k]);
            end else armed[fired[k]] = 1'b0;
         end
      end else if (rt == htw_pkg::REQ_REGISTER) begin
         if (tmo == 0 || (64'(tmo) >> htw_pkg::SPAN_BITS) != 0)
            push_one(htw_pkg::KIND_RANGE, id);
         else if (armed[id]) push_one(htw_pkg::KIND_BUSY, id);
         else begin
            armed[id] = 1'b1;
            killed[id] = 1'b0;
            rearm[id] = per;
            rearm_gap[id] = tmo;
            due_at[id] = jiffies + htw_pkg::NOW_W'(tmo);
            file_timer(id);
            push_one(htw_pkg::KIND_ACCEPTED, id);
         end
      end else if (rt == htw_pkg::REQ_CANCEL) begin
         if (!armed[id] || killed[id]) push_one(htw_pkg::KIND_UNKNOWN, id);
         else begin
            killed[id] = 1'b1;
            push_one(htw_pkg::KIND_ACCEPTED, id);
         end
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         jiffies = 1;
         for (int i = 0; i < htw_pkg::MAX_TIMERS; i++) begin
            armed[i] = 1'b0;
            killed[i] = 1'b0;
         end
         for (int i = 0; i < htw_pkg::BUCKETS; i++) slot_first[i] = htw_pkg::MAX_TIMERS;
         outcome_q.delete();
         fail_count <= 0;
         fired_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("response transfer with nothing expected: kind %0d id %0d",
                      rsp_result_kind, rsp_fired_id);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_q.pop_front();
               if (want.kind == htw_pkg::KIND_FIRED) fired_count <= fired_count + 1;
               if (rsp_result_kind !== want.kind || rsp_fired_id !== want.id ||
                   rsp_tick_count !== want.count || rsp_last !== want.last) begin
                  if (rsp_result_kind !== want.kind)
                     $error("result_kind expected %0d actual %0d", want.kind, rsp_result_kind);
                  if (rsp_fired_id !== want.id)
                     $error("fired_id expected %0d actual %0d", want.id, rsp_fired_id);
                  if (rsp_tick_count !== want.count)
                     $error("tick_count expected %0d actual %0d", want.count, rsp_tick_count);
                  if (rsp_last !== want.last)
                     $error("last expected %0d actual %0d", want.last, rsp_last);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict after the pop so same-edge outputs stay in order
         if (req_valid && !req_stall)
            wheel_step(req_type, int'(req_timer_id), req_timeout, req_periodic);
         pending_count <= outcome_q.size();
      end
   end

endmodule

/* verif/tb_hierarchical_timer_wheel.sv */
// testbench top for the timer wheel: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_hierarchical_timer_wheel;

   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int TOTAL_ITEMS = 230;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_type = htw_pkg::REQ_TICK;
   logic [htw_pkg::ID_W-1:0]   req_timer_id = '0;
   logic [htw_pkg::TMO_W-1:0]  req_timeout = '0;
   logic                       req_periodic = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [htw_pkg::KIND_W-1:0] rsp_result_kind;
   logic [htw_pkg::ID_W-1:0]   rsp_fired_id;
   logic [htw_pkg::NOW_W-1:0]  rsp_tick_count;
   logic                       rsp_last;

   int  fail_count;
   int  pending_count;
   int  fired_count;
   int  cycle_count = 0;
   int  sent_count = 0;
   bit  hold_done = 1'b0;

   always #2 clock = ~clock;

   hierarchical_timer_wheel uut (.*);

   htw_checker checker_i (.*);

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[hierarchical_timer_wheel] ERROR");
         $finish;
      end
   end

   // receiver: mostly ready, random stall runs, one long hold-off early on
   initial begin
      int hold;
      @(negedge reset);
      while (sent_count < 8) @(posedge clock);
      rsp_stall <= 1'b1;
      for (hold = 0; hold < 400; hold++) @(posedge clock);
      rsp_stall <= 1'b0;
      hold_done = 1'b1;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 9) < 2) rsp_stall <= 1'b1;
         else if ($urandom_range(0, 3) == 0) rsp_stall <= 1'b0;
         else if (sent_count > 150 && sent_count < 190) rsp_stall <= 1'b0;
      end
   end

   // offer one request and hold it until the block takes it
   task automatic offer(logic [1:0] rt, int id, logic [htw_pkg::TMO_W-1:0] tmo, logic per);
      req_valid <= 1'b1;
      req_type <= rt;
      req_timer_id <= htw_pkg::ID_W'(id);
      req_timeout <= tmo;
      req_periodic <= per;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
   endtask

   task automatic go_idle(int gap);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic ticks(int n);
      for (int i = 0; i < n; i++) offer(htw_pkg::REQ_TICK, 0, '0, 1'b0);
   endtask

   // random request biased toward short timeouts so timers fire often
   task automatic random_request();
      int pick;
      logic [htw_pkg::TMO_W-1:0] tmo;
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0: tmo = htw_pkg::TMO_W'($urandom());
         1: tmo = htw_pkg::TMO_W'($urandom_range(0, 4200));
         default: tmo = htw_pkg::TMO_W'($urandom_range(1, 70));
      endcase
      if (pick < 55)
         offer(htw_pkg::REQ_TICK, $urandom_range(0, 63), htw_pkg::TMO_W'($urandom()),
               1'($urandom()));
      else if (pick < 85)
         offer(htw_pkg::REQ_REGISTER, $urandom_range(0, 15), tmo, 1'($urandom()));
      else if (pick < 97)
         offer(htw_pkg::REQ_CANCEL, $urandom_range(0, 15), tmo, 1'($urandom()));
      else
         offer(htw_pkg::REQ_UNUSED, $urandom_range(0, 63), htw_pkg::TMO_W'($urandom()),
               1'($urandom()));
   endtask

   initial begin
      int burst;
      int run;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every code, busy, range, cancel paths, quiet tick
      offer(htw_pkg::REQ_TICK, 0, '0, 1'b0);                 // quiet tick
      offer(htw_pkg::REQ_UNUSED, 63, '1, 1'b1);              // ignored code
      offer(htw_pkg::REQ_REGISTER, 0, '0, 1'b0);             // zero timeout
      offer(htw_pkg::REQ_REGISTER, 63, '1, 1'b1);            // full-width timeout, top level
      offer(htw_pkg::REQ_REGISTER, 63, 24'd5, 1'b0);         // busy id
      offer(htw_pkg::REQ_REGISTER, 1, 24'd1, 1'b1);          // periodic every tick
      offer(htw_pkg::REQ_REGISTER, 2, 24'd1, 1'b0);          // same bucket, fifo order
      offer(htw_pkg::REQ_REGISTER, 3, 24'd2, 1'b0);
      offer(htw_pkg::REQ_CANCEL, 3, '0, 1'b0);               // cancelled entry dropped silently
      offer(htw_pkg::REQ_CANCEL, 3, '0, 1'b0);               // already cancelled
      offer(htw_pkg::REQ_CANCEL, 9, '0, 1'b0);               // never armed
      offer(htw_pkg::REQ_REGISTER, 3, 24'd4, 1'b0);          // busy until drained
      offer(htw_pkg::REQ_REGISTER, 4, 24'd64, 1'b0);         // level one
      offer(htw_pkg::REQ_REGISTER, 5, 24'd4096, 1'b1);       // level two
      ticks(5);
      offer(htw_pkg::REQ_CANCEL, 1, '0, 1'b0);
      ticks(2);
      go_idle(3);

      // random part in bursts; tick runs carry the counter across level-one rollovers
      while (sent_count < TOTAL_ITEMS) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && sent_count < TOTAL_ITEMS; i++) random_request();
         if ($urandom_range(0, 7) == 0) begin
            run = $urandom_range(20, 80);
            if (run > TOTAL_ITEMS - sent_count) run = TOTAL_ITEMS - sent_count;
            ticks(run);
         end
         if ($urandom_range(0, 2) == 0) go_idle($urandom_range(1, 6));
      end
      req_valid <= 1'b0;

      while (pending_count != 0 || !hold_done) @(posedge clock);
      repeat (600) @(posedge clock);

      $display("covered %0d requests, %0d timer firings, ended at cycle %0d",
               sent_count, fired_count, cycle_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[hierarchical_timer_wheel] OK");
      else
         $display("[hierarchical_timer_wheel] ERROR");
      $finish;
   end

endmodule
